### design/ssbs_pkg.sv
// Shared types, constants and segment tables for the bargraph serializer.
`timescale 1ns / 1ps
package ssbs_pkg;

  localparam int WORD_BITS = 32;
  localparam int IDX_W     = $clog2(WORD_BITS);
  localparam int VAL_W     = 16;
  localparam int BAR_W     = 4;
  localparam int DIG_W     = 4;

  // Reciprocal multipliers: (x * MUL) >> SHIFT equals x / divisor over the range used.
  // 1000 holds for any 16-bit value, 100 below 1000, 10 below 100.
  localparam int PROD_W        = 2 * VAL_W + 1;
  localparam int DIV1000_MUL   = 67109;
  localparam int DIV1000_SHIFT = 26;
  localparam int DIV100_MUL    = 41;
  localparam int DIV100_SHIFT  = 12;
  localparam int DIV10_MUL     = 103;
  localparam int DIV10_SHIFT   = 10;

  typedef logic [WORD_BITS-1:0] word_t;

  // Decimal digits of value mod 1000 plus the bar level, handed to the word builder.
  typedef struct packed {
    logic             valid;
    logic [DIG_W-1:0] hund;
    logic [DIG_W-1:0] tens;
    logic [DIG_W-1:0] ones;
    logic [BAR_W-1:0] bar;
  } digits_t;

  // Control into the shift row.
  typedef struct packed {
    logic load;
    logic advance;
  } chain_ctrl_t;

  // Status out of the shift row.
  typedef struct packed {
    logic active;
    logic last;
  } chain_stat_t;

  // Outer displays: P C D E - - - - - - - - G F A B
  function automatic logic [15:0] outer_digit(input logic [DIG_W-1:0] d);
    logic [15:0] p;
    case (d)
      4'd0:    p = 16'h7007;
      4'd1:    p = 16'h4001;
      4'd2:    p = 16'h300B;
      4'd3:    p = 16'h600B;
      4'd4:    p = 16'h400D;
      4'd5:    p = 16'h600E;
      4'd6:    p = 16'h700E;
      4'd7:    p = 16'h4003;
      4'd8:    p = 16'h700F;
      4'd9:    p = 16'h600F;
      default: p = 16'h0000;
    endcase
    return p;
  endfunction

  // Middle display: segments in bits 11..4
  function automatic logic [15:0] middle_digit(input logic [DIG_W-1:0] d);
    logic [15:0] p;
    case (d)
      4'd0:    p = 16'h0770;
      4'd1:    p = 16'h0410;
      4'd2:    p = 16'h03B0;
      4'd3:    p = 16'h06B0;
      4'd4:    p = 16'h04D0;
      4'd5:    p = 16'h06E0;
      4'd6:    p = 16'h07E0;
      4'd7:    p = 16'h0430;
      4'd8:    p = 16'h07F0;
      4'd9:    p = 16'h06F0;
      default: p = 16'h0000;
    endcase
    return p;
  endfunction

  // Thermometer pattern; levels above eight light nothing.
  function automatic logic [15:0] bar_pattern(input logic [BAR_W-1:0] lvl);
    logic [15:0] p;
    case (lvl)
      4'd1:    p = 16'h0100;
      4'd2:    p = 16'h0300;
      4'd3:    p = 16'h0700;
      4'd4:    p = 16'h0F00;
      4'd5:    p = 16'h0F80;
      4'd6:    p = 16'h0FC0;
      4'd7:    p = 16'h0FE0;
      4'd8:    p = 16'h0FF0;
      default: p = 16'h0000;
    endcase
    return p;
  endfunction

  function automatic word_t build_word(input digits_t d);
    word_t w;
    w = {outer_digit(d.hund), 16'h0000}
      | {16'h0000, middle_digit(d.tens)}
      | {16'h0000, outer_digit(d.ones)}
      | {bar_pattern(d.bar), 16'h0000};
    return w;
  endfunction

endpackage

### design/ssbs_if.sv
// Valid/ready channel interfaces for the input item and the serial result item.
`timescale 1ns / 1ps
interface ssbs_in_if;
  logic                       valid;
  logic                       ready;
  logic [ssbs_pkg::VAL_W-1:0] display_value;
  logic [ssbs_pkg::BAR_W-1:0] bar_level;

  modport source (output valid, display_value, bar_level, input ready);
  modport sink   (input valid, display_value, bar_level, output ready);
endinterface

interface ssbs_out_if;
  logic                       valid;
  logic                       ready;
  logic                       serial_data;
  logic [ssbs_pkg::IDX_W-1:0] bit_index;
  logic                       last;

  modport source (output valid, serial_data, bit_index, last, input ready);
  modport sink   (input valid, serial_data, bit_index, last, output ready);
endinterface

### design/ssbs_bcd_conv.sv
// Three-step decimal splitter (value mod 1000 into digits) by reciprocal multiplication.
`timescale 1ns / 1ps
module ssbs_bcd_conv (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ssbs_pkg::VAL_W-1:0] value,
  input  logic [ssbs_pkg::BAR_W-1:0] bar,
  input  logic                       take,
  output logic                       idle,
  output ssbs_pkg::digits_t          digits
);

  logic                          ph1_r, ph1_nxt;
  logic                          ph2_r, ph2_nxt;
  logic                          ph3_r, ph3_nxt;
  logic                          done_r, done_nxt;
  logic [ssbs_pkg::VAL_W-1:0]    rem_r, rem_nxt;
  logic [ssbs_pkg::DIG_W-1:0]    hund_r, hund_nxt;
  logic [ssbs_pkg::DIG_W-1:0]    tens_r, tens_nxt;
  logic [ssbs_pkg::DIG_W-1:0]    ones_r, ones_nxt;
  logic [ssbs_pkg::BAR_W-1:0]    bar_r, bar_nxt;
  logic [ssbs_pkg::PROD_W-1:0]   prod_k;
  logic [ssbs_pkg::VAL_W-1:0]    thou;
  logic [ssbs_pkg::VAL_W-1:0]    prod_h;
  logic [ssbs_pkg::DIG_W-1:0]    hund;
  logic [ssbs_pkg::VAL_W-1:0]    prod_t;
  logic [ssbs_pkg::DIG_W-1:0]    tens;

  // quotients of the working remainder; each is exact in the phase that uses it
  assign prod_k = ssbs_pkg::PROD_W'(rem_r) * ssbs_pkg::PROD_W'(ssbs_pkg::DIV1000_MUL);
  assign thou   = ssbs_pkg::VAL_W'(prod_k >> ssbs_pkg::DIV1000_SHIFT);
  assign prod_h = rem_r * ssbs_pkg::VAL_W'(ssbs_pkg::DIV100_MUL);
  assign hund   = ssbs_pkg::DIG_W'(prod_h >> ssbs_pkg::DIV100_SHIFT);
  assign prod_t = rem_r * ssbs_pkg::VAL_W'(ssbs_pkg::DIV10_MUL);
  assign tens   = ssbs_pkg::DIG_W'(prod_t >> ssbs_pkg::DIV10_SHIFT);

  // phase flags: strip thousands, then hundreds, then tens and ones
  always_comb begin
    ph1_nxt  = start;
    ph2_nxt  = ph1_r;
    ph3_nxt  = ph2_r;
    done_nxt = ph3_r || (done_r && !take);
  end

  always_comb begin
    rem_nxt  = rem_r;
    hund_nxt = hund_r;
    tens_nxt = tens_r;
    ones_nxt = ones_r;
    bar_nxt  = bar_r;
    if (start) begin
      rem_nxt = value;
      bar_nxt = bar;
    end
    if (ph1_r) begin
      rem_nxt = rem_r - thou * ssbs_pkg::VAL_W'(1000);
    end
    if (ph2_r) begin
      hund_nxt = hund;
      rem_nxt  = rem_r - ssbs_pkg::VAL_W'(hund) * ssbs_pkg::VAL_W'(100);
    end
    if (ph3_r) begin
      tens_nxt = tens;
      ones_nxt = ssbs_pkg::DIG_W'(rem_r - ssbs_pkg::VAL_W'(tens) * ssbs_pkg::VAL_W'(10));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph1_r  <= 1'b0;
      ph2_r  <= 1'b0;
      ph3_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      ph1_r  <= ph1_nxt;
      ph2_r  <= ph2_nxt;
      ph3_r  <= ph3_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    hund_r <= hund_nxt;
    tens_r <= tens_nxt;
    ones_r <= ones_nxt;
    bar_r  <= bar_nxt;
  end

  assign idle         = !ph1_r && !ph2_r && !ph3_r && !done_r;
  assign digits.valid = done_r;
  assign digits.hund  = hund_r;
  assign digits.tens  = tens_r;
  assign digits.ones  = ones_r;
  assign digits.bar   = bar_r;

endmodule

### design/ssbs_cell.sv
// One bit cell of the shift row: parallel load or take the neighbor's bit.
`timescale 1ns / 1ps
module ssbs_cell (
  input  logic clk,
  input  logic load,
  input  logic shift,
  input  logic load_bit,
  input  logic neighbor_bit,
  output logic data
);

  logic data_r, data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (load) begin
      data_nxt = load_bit;
    end else if (shift) begin
      data_nxt = neighbor_bit;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

### design/ssbs_chain.sv
// Row of shift cells with the bit position counter; cell 0 drives the serial bit.
`timescale 1ns / 1ps
module ssbs_chain (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ssbs_pkg::chain_ctrl_t        ctrl,
  input  ssbs_pkg::word_t              word,
  output logic                         serial_bit,
  output logic [ssbs_pkg::IDX_W-1:0]   index,
  output ssbs_pkg::chain_stat_t        stat
);

  logic [ssbs_pkg::WORD_BITS-1:0] cell_q;
  logic [ssbs_pkg::WORD_BITS-1:0] cell_in;
  logic                           active_r, active_nxt;
  logic [ssbs_pkg::IDX_W-1:0]     index_r, index_nxt;
  logic                           last;
  logic                           shift;

  assign cell_in = {1'b0, cell_q[ssbs_pkg::WORD_BITS-1:1]};
  assign shift   = ctrl.advance;

  for (genvar g = 0; g < ssbs_pkg::WORD_BITS; g++) begin : g_cell
    ssbs_cell u_cell (
      .clk          (clk),
      .load         (ctrl.load),
      .shift        (shift),
      .load_bit     (word[g]),
      .neighbor_bit (cell_in[g]),
      .data         (cell_q[g])
    );
  end

  assign last = (index_r == ssbs_pkg::IDX_W'(ssbs_pkg::WORD_BITS - 1));

  always_comb begin
    active_nxt = active_r;
    index_nxt  = index_r;
    if (ctrl.load) begin
      active_nxt = 1'b1;
      index_nxt  = '0;
    end else if (ctrl.advance) begin
      index_nxt = index_r + ssbs_pkg::IDX_W'(1);
      if (last) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      index_r  <= '0;
    end else begin
      active_r <= active_nxt;
      index_r  <= index_nxt;
    end
  end

  assign serial_bit  = cell_q[0];
  assign index       = index_r;
  assign stat.active = active_r;
  assign stat.last   = last;

endmodule

### design/seven_segment_bargraph_serializer_unit.sv
// Top level: seven-segment and bargraph word builder with serial shift-out.
`timescale 1ns / 1ps
// Each input item (display_value, bar_level) becomes one 32-bit shift-register
// word: hundreds, tens and ones of display_value mod 1000 through the segment
// tables, ORed with the bargraph thermometer (levels above eight light none).
// The word leaves LSB first as 32 result items, one bit per item, with
// bit_index giving the position and last set on bit 31.
// Sustained input rate is set by the serial output: the 32-cell shift row
// moves one bit per cycle while out_if.ready is high. The decimal split is a
// three-step reciprocal-multiply unit (drop thousands, then hundreds, then
// tens and ones); it runs on the next item while the row is still shifting
// the previous word, so words stream out back to back with no gap. From idle,
// the first serial bit appears after the phase steps, done flag and row load.
// One item can wait in the converter while a word shifts; in_if.ready drops
// until the row takes the converted word and rises the cycle after.
module seven_segment_bargraph_serializer_unit (
  input  logic        clk,
  input  logic        rst_n,
  ssbs_in_if.sink     in_if,
  ssbs_out_if.source  out_if
);

  logic                         conv_idle;
  ssbs_pkg::digits_t            digits;
  ssbs_pkg::chain_ctrl_t        ctrl;
  ssbs_pkg::chain_stat_t        stat;
  ssbs_pkg::word_t              word;
  logic                         serial_bit;
  logic [ssbs_pkg::IDX_W-1:0]   index;
  logic                         accept;

  // converter takes a new item only when it holds nothing
  assign in_if.ready = conv_idle;
  assign accept      = in_if.valid && conv_idle;

  ssbs_bcd_conv u_conv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept),
    .value  (in_if.display_value),
    .bar    (in_if.bar_level),
    .take   (ctrl.load),
    .idle   (conv_idle),
    .digits (digits)
  );

  // segment lookup and OR straight from the converter's registers
  assign word = ssbs_pkg::build_word(digits);

  // row advances on each taken bit; reloads when empty or as bit 31 leaves
  assign ctrl.advance = stat.active && out_if.ready;
  assign ctrl.load    = digits.valid &&
                        (!stat.active || (out_if.ready && stat.last));

  ssbs_chain u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .word       (word),
    .serial_bit (serial_bit),
    .index      (index),
    .stat       (stat)
  );

  assign out_if.valid       = stat.active;
  assign out_if.serial_data = serial_bit;
  assign out_if.bit_index   = index;
  assign out_if.last        = stat.last;

endmodule

### test/seven_segment_bargraph_serializer_unit_tb.sv
// Testbench for the seven-segment and bargraph serializer: word prediction and serial bit checks.
`timescale 1ns / 1ps
module seven_segment_bargraph_serializer_unit_tb;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 64;

  // One serial bit as the result channel carries it.
  typedef struct packed {
    logic                       serial_data;
    logic [ssbs_pkg::IDX_W-1:0] bit_index;
    logic                       last;
  } serial_bit_t;

  // Segment tables: outer displays (hundreds, ones) and the middle display (tens).
  localparam logic [15:0] OUTER_SEG [10] = '{
    16'h7007, 16'h4001, 16'h300B, 16'h600B, 16'h400D,
    16'h600E, 16'h700E, 16'h4003, 16'h700F, 16'h600F
  };
  localparam logic [15:0] MIDDLE_SEG [10] = '{
    16'h0770, 16'h0410, 16'h03B0, 16'h06B0, 16'h04D0,
    16'h06E0, 16'h07E0, 16'h0430, 16'h07F0, 16'h06F0
  };
  localparam logic [15:0] BAR_LEDS [9] = '{
    16'h0000, 16'h0100, 16'h0300, 16'h0700, 16'h0F00,
    16'h0F80, 16'h0FC0, 16'h0FE0, 16'h0FF0
  };

  logic clk = 1'b0;
  logic rst_n;

  ssbs_in_if  in_ch ();
  ssbs_out_if out_ch ();

  seven_segment_bargraph_serializer_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch.sink),
    .out_if (out_ch.source)
  );

  always #1 clk = ~clk;

  serial_bit_t pending_bits[$];
  int          mismatch_count = 0;
  int          idle_cycles    = 0;

  // Receiver controls: a rotating stall pattern, plus a one-shot long hold-off.
  logic [15:0] rx_pattern = 16'hFFFF;
  bit          hold_req   = 1'b0;
  int          hold_left  = 0;

  // Expected shift-register word for one display value and bar level.
  function automatic ssbs_pkg::word_t predict_shift_word(
      logic [ssbs_pkg::VAL_W-1:0] value, logic [ssbs_pkg::BAR_W-1:0] level);
    int              shown;
    ssbs_pkg::word_t w;
    shown = int'(value) % 1000;
    w = {OUTER_SEG[4'(shown / 100)], 16'h0000};
    w |= {16'h0000, MIDDLE_SEG[4'((shown / 10) % 10)]};
    w |= {16'h0000, OUTER_SEG[4'(shown % 10)]};
    if (level <= 4'd8) w |= {BAR_LEDS[level], 16'h0000};
    return w;
  endfunction

  // Accepted input item -> 32 expected serial bits, LSB first.
  always @(posedge clk) begin
    ssbs_pkg::word_t w;
    serial_bit_t     b;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      w = predict_shift_word(in_ch.display_value, in_ch.bar_level);
      for (int i = 0; i < ssbs_pkg::WORD_BITS; i++) begin
        b.serial_data = w[ssbs_pkg::IDX_W'(i)];
        b.bit_index   = ssbs_pkg::IDX_W'(i);
        b.last        = (i == ssbs_pkg::WORD_BITS - 1);
        pending_bits.push_back(b);
      end
    end
  end

  // Each accepted result item against the oldest expected bit.
  always @(posedge clk) begin
    serial_bit_t exp_bit;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_bits.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result item: expected none, actual data=%0b idx=%0d last=%0b",
                 $time, out_ch.serial_data, out_ch.bit_index, out_ch.last);
      end else begin
        exp_bit = pending_bits.pop_front();
        if (out_ch.serial_data !== exp_bit.serial_data) begin
          mismatch_count++;
          $display("%0t: serial_data mismatch at bit %0d: expected %0b, actual %0b",
                   $time, exp_bit.bit_index, exp_bit.serial_data, out_ch.serial_data);
        end
        if (out_ch.bit_index !== exp_bit.bit_index) begin
          mismatch_count++;
          $display("%0t: bit_index mismatch: expected %0d, actual %0d",
                   $time, exp_bit.bit_index, out_ch.bit_index);
        end
        if (out_ch.last !== exp_bit.last) begin
          mismatch_count++;
          $display("%0t: last mismatch at bit %0d: expected %0b, actual %0b",
                   $time, exp_bit.bit_index, exp_bit.last, out_ch.last);
        end
      end
    end
  end

  // Receiver: long hold-off on request, else follow the rotating pattern.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= rx_pattern[0];
      rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
    end
  end

  // Watchdog: too long with no item moving on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: watchdog expired, %0d bits still expected", $time, pending_bits.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offer one item and hold it until accepted; valid stays high afterward.
  task automatic send_item(logic [ssbs_pkg::VAL_W-1:0] value,
                           logic [ssbs_pkg::BAR_W-1:0] level);
    in_ch.valid         <= 1'b1;
    in_ch.display_value <= value;
    in_ch.bar_level     <= level;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Close a burst: drop valid and stay quiet for the given number of cycles.
  task automatic pause_sender(int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [ssbs_pkg::VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0, 1:    return ssbs_pkg::VAL_W'($urandom_range(0, 999));
      2: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return '1;
          2:       return ssbs_pkg::VAL_W'(999);
          default: return ssbs_pkg::VAL_W'(1000);
        endcase
      end
      default: return ssbs_pkg::VAL_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [ssbs_pkg::BAR_W-1:0] rand_level();
    if ($urandom_range(0, 3) == 0) return ssbs_pkg::BAR_W'($urandom_range(9, 15));
    return ssbs_pkg::BAR_W'($urandom_range(0, 8));
  endfunction

  // Each digit in at least one position, all bar levels including those above eight,
  // digit eight everywhere, and values at and past 1000.
  task automatic test_digit_and_bar_table();
    logic [ssbs_pkg::VAL_W-1:0] vals [16] = '{
      16'd0, 16'd65535, 16'd999, 16'd888, 16'd1000, 16'd123, 16'd456, 16'd789,
      16'd907, 16'd12, 16'd345, 16'd678, 16'd90, 16'd1999, 16'd64999, 16'd5
    };
    rx_pattern = 16'hFFFF;
    for (int i = 0; i < 16; i++) send_item(vals[i], ssbs_pkg::BAR_W'(i));
    pause_sender(40);
  endtask

  // Receiver holds off while items keep coming, so the block backs up.
  task automatic test_output_holdoff();
    rx_pattern = 16'hFFFF;
    hold_req   = 1'b1;
    for (int i = 0; i < 8; i++) send_item(rand_value(), rand_level());
    pause_sender(5);
  endtask

  // Random items back to back with the receiver always ready.
  task automatic test_random_free_flow(int n_items);
    rx_pattern = 16'hFFFF;
    for (int i = 0; i < n_items; i++) send_item(rand_value(), rand_level());
    pause_sender(3);
  endtask

  // Random bursts and gaps on the sender, fresh stall pattern per burst.
  task automatic test_random_bursts(int n_items);
    int sent = 0;
    int burst;
    while (sent < n_items) begin
      if ($urandom_range(0, 3) == 0) rx_pattern = 16'hFFFF;
      else                           rx_pattern = 16'($urandom_range(1, 16'hFFFF));
      burst = $urandom_range(1, 8);
      for (int i = 0; i < burst && sent < n_items; i++) begin
        send_item(rand_value(), rand_level());
        sent++;
      end
      if ($urandom_range(0, 4) != 0) pause_sender($urandom_range(1, 40));
    end
    pause_sender(1);
  endtask

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.display_value = '0;
    in_ch.bar_level     = '0;
    out_ch.ready        = 1'b0;
    rst_n               = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_digit_and_bar_table();
    test_output_holdoff();
    test_random_free_flow(60);
    test_random_bursts(300);

    // Drain: everything predicted must come out, then watch for strays.
    rx_pattern = 16'hFFFF;
    while (pending_bits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
design/ssbs_pkg.sv
design/ssbs_if.sv
design/ssbs_bcd_conv.sv
design/ssbs_cell.sv
design/ssbs_chain.sv
design/seven_segment_bargraph_serializer_unit.sv
test/seven_segment_bargraph_serializer_unit_tb.sv
